// ===== rtl/wsdf_pkg.sv =====
// Package for the WebSocket frame deframer: parse phases, event codes,
// opcodes, length codes, register indexes and the result word type.
// No dependencies; used by every module of the block.
`default_nettype none

package wsdf_pkg;

    // Configuration port geometry.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes (word address bits of paddr).
    localparam logic REG_REQUIRE_MASK = 1'b0;

    // Frame opcodes.
    localparam logic [3:0] OP_CONT     = 4'h0;
    localparam logic [3:0] OP_BIN      = 4'h2;
    localparam logic [3:0] OP_CONN_END = 4'h8;
    localparam logic [3:0] OP_PING     = 4'h9;
    localparam logic [3:0] OP_PONG     = 4'hA;

    // Length codes that announce an extended length.
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Extended length sizes in bytes.
    localparam logic [3:0] LEN_BYTES_16 = 4'd2;
    localparam logic [3:0] LEN_BYTES_64 = 4'd8;

    // Last byte index of the masking key.
    localparam logic [2:0] KEY_LAST = 3'd3;

    // Parse phases of the frame header and payload.
    typedef enum logic [2:0] {
        PH_H1   = 3'd0,
        PH_H2   = 3'd1,
        PH_LEN  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    // Event codes reported with each result word.
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PING    = 3'd1,
        EV_PONG    = 3'd2,
        EV_CLOSE   = 3'd3,
        EV_NO_MASK = 3'd4,
        EV_BAD     = 3'd5,
        EV_IGNORED = 3'd6
    } event_t;

    // One result word.
    typedef struct packed {
        logic       data_valid;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic [3:0] message_opcode;
        logic       frame_last;
        logic       message_last;
        event_t     event_res;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/wsdf_parser.sv =====
// Frame parser: holds the parse state and computes one result word per
// accepted stream byte. Depends on wsdf_pkg.
`default_nettype none

module wsdf_parser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       stream_byte,
    input  wire logic             require_mask,
    output wsdf_pkg::result_t     result
);

    wsdf_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  first_header_reg, first_header_next;
    logic        mask_flag_reg, mask_flag_next;
    logic [6:0]  length_code_reg, length_code_next;
    logic [2:0]  byte_counter_reg, byte_counter_next;
    // Shared length register: accumulates the length, then counts payload down.
    logic [63:0] length_reg, length_next;
    logic [31:0] masking_key_reg, masking_key_next;
    logic [1:0]  key_position_reg, key_position_next;
    logic [3:0]  held_opcode_reg, held_opcode_next;
    logic        in_frag_reg, in_frag_next;
    logic        close_seen_reg, close_seen_next;

    logic        length_done;
    logic        do_finish;
    logic        known_mask;
    logic [63:0] known_length;
    logic [3:0]  op;
    logic [3:0]  counter_inc;
    logic [3:0]  length_need;
    logic [7:0]  key_byte;

    assign op          = first_header_reg[3:0];
    assign counter_inc = {1'b0, byte_counter_reg} + 4'd1;
    assign length_need = (length_code_reg == wsdf_pkg::LEN_CODE_16) ?
                         wsdf_pkg::LEN_BYTES_16 : wsdf_pkg::LEN_BYTES_64;

    // Key byte for the current payload position, most significant first.
    always_comb begin
        case (key_position_reg)
            2'd0:    key_byte = masking_key_reg[31:24];
            2'd1:    key_byte = masking_key_reg[23:16];
            2'd2:    key_byte = masking_key_reg[15:8];
            default: key_byte = masking_key_reg[7:0];
        endcase
    end

    // Next state and result word.
    always_comb begin
        phase_next        = phase_reg;
        first_header_next = first_header_reg;
        mask_flag_next    = mask_flag_reg;
        length_code_next  = length_code_reg;
        byte_counter_next = byte_counter_reg;
        length_next       = length_reg;
        masking_key_next  = masking_key_reg;
        key_position_next = key_position_reg;
        held_opcode_next  = held_opcode_reg;
        in_frag_next      = in_frag_reg;
        close_seen_next   = close_seen_reg;
        length_done       = 1'b0;
        do_finish         = 1'b0;
        known_mask        = mask_flag_reg;
        known_length      = length_reg;

        result.data_valid   = 1'b0;
        result.payload_byte = 8'h00;
        result.frame_last   = 1'b0;
        result.message_last = 1'b0;
        result.event_res    = wsdf_pkg::EV_NONE;

        if (close_seen_reg) begin
            result.event_res = wsdf_pkg::EV_IGNORED;
        end else begin
            unique case (phase_reg)
                wsdf_pkg::PH_H1: begin
                    first_header_next = stream_byte;
                    phase_next        = wsdf_pkg::PH_H2;
                end
                wsdf_pkg::PH_H2: begin
                    mask_flag_next   = stream_byte[7];
                    length_code_next = stream_byte[6:0];
                    if (!in_frag_reg && op == wsdf_pkg::OP_CONT) begin
                        // A message cannot start with a continuation frame.
                        result.event_res = wsdf_pkg::EV_BAD;
                        close_seen_next  = 1'b1;
                        phase_next       = wsdf_pkg::PH_H1;
                    end else begin
                        if (!in_frag_reg) begin
                            held_opcode_next = op;
                            if (!first_header_reg[7]) begin
                                in_frag_next = 1'b1;
                            end
                        end
                        if (stream_byte[6:0] == wsdf_pkg::LEN_CODE_16 ||
                            stream_byte[6:0] == wsdf_pkg::LEN_CODE_64) begin
                            byte_counter_next = 3'd0;
                            length_next       = 64'd0;
                            phase_next        = wsdf_pkg::PH_LEN;
                        end else begin
                            length_next  = {57'd0, stream_byte[6:0]};
                            known_length = {57'd0, stream_byte[6:0]};
                            known_mask   = stream_byte[7];
                            length_done  = 1'b1;
                        end
                    end
                end
                wsdf_pkg::PH_LEN: begin
                    length_next  = {length_reg[55:0], stream_byte};
                    known_length = {length_reg[55:0], stream_byte};
                    if (counter_inc >= length_need) begin
                        byte_counter_next = 3'd0;
                        length_done       = 1'b1;
                    end else begin
                        byte_counter_next = counter_inc[2:0];
                    end
                end
                wsdf_pkg::PH_KEY: begin
                    masking_key_next = {masking_key_reg[23:0], stream_byte};
                    if (byte_counter_reg >= wsdf_pkg::KEY_LAST) begin
                        byte_counter_next = 3'd0;
                        if (length_reg == 64'd0) begin
                            do_finish = 1'b1;
                        end else begin
                            key_position_next = 2'd0;
                            phase_next        = wsdf_pkg::PH_DATA;
                        end
                    end else begin
                        byte_counter_next = counter_inc[2:0];
                    end
                end
                wsdf_pkg::PH_DATA: begin
                    result.data_valid   = 1'b1;
                    result.payload_byte = mask_flag_reg ? (stream_byte ^ key_byte)
                                                        : stream_byte;
                    key_position_next   = key_position_reg + 2'd1;
                    length_next         = length_reg - 64'd1;
                    if (length_reg == 64'd1) begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    phase_next = wsdf_pkg::PH_H1;
                end
            endcase

            // The length is complete: check the mask, then key, payload or end.
            if (length_done) begin
                if (require_mask && !known_mask) begin
                    result.event_res = wsdf_pkg::EV_NO_MASK;
                    close_seen_next  = 1'b1;
                    phase_next       = wsdf_pkg::PH_H1;
                end else if (known_mask) begin
                    byte_counter_next = 3'd0;
                    masking_key_next  = 32'd0;
                    phase_next        = wsdf_pkg::PH_KEY;
                end else if (known_length == 64'd0) begin
                    do_finish = 1'b1;
                end else begin
                    key_position_next = 2'd0;
                    phase_next        = wsdf_pkg::PH_DATA;
                end
            end

            // Frame end: report the frame's event and close on errors.
            if (do_finish) begin
                result.frame_last = 1'b1;
                phase_next        = wsdf_pkg::PH_H1;
                if (first_header_reg[6:4] != 3'd0) begin
                    result.event_res = wsdf_pkg::EV_BAD;
                    close_seen_next  = 1'b1;
                end else if (op <= wsdf_pkg::OP_BIN) begin
                    if (first_header_reg[7]) begin
                        result.message_last = 1'b1;
                        in_frag_next        = 1'b0;
                    end
                end else if (op == wsdf_pkg::OP_CONN_END) begin
                    result.event_res = wsdf_pkg::EV_CLOSE;
                    close_seen_next  = 1'b1;
                end else if (op == wsdf_pkg::OP_PING) begin
                    result.event_res = wsdf_pkg::EV_PING;
                end else if (op == wsdf_pkg::OP_PONG) begin
                    result.event_res = wsdf_pkg::EV_PONG;
                end else begin
                    result.event_res = wsdf_pkg::EV_BAD;
                    close_seen_next  = 1'b1;
                end
            end
        end

        result.frame_opcode   = first_header_next[3:0];
        result.message_opcode = held_opcode_next;
    end

    // Control state, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= wsdf_pkg::PH_H1;
            first_header_reg <= 8'h00;
            byte_counter_reg <= 3'd0;
            held_opcode_reg  <= 4'h0;
            in_frag_reg      <= 1'b0;
            close_seen_reg   <= 1'b0;
        end else if (step) begin
            phase_reg        <= phase_next;
            first_header_reg <= first_header_next;
            byte_counter_reg <= byte_counter_next;
            held_opcode_reg  <= held_opcode_next;
            in_frag_reg      <= in_frag_next;
            close_seen_reg   <= close_seen_next;
        end
    end

    // Frame fields, always written before they are read.
    always_ff @(posedge aclk) begin
        if (step) begin
            mask_flag_reg    <= mask_flag_next;
            length_code_reg  <= length_code_next;
            length_reg       <= length_next;
            masking_key_reg  <= masking_key_next;
            key_position_reg <= key_position_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wsdf_out_reg.sv =====
// Result register of the deframer: holds one result word until the
// receiver takes it. Depends on wsdf_pkg.
`default_nettype none

module wsdf_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire wsdf_pkg::result_t result_in,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output logic                   free,
    output wsdf_pkg::result_t      result_out
);

    logic              valid_reg;
    wsdf_pkg::result_t word_reg;

    // The register can take a word when empty or when its word leaves now.
    assign free       = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign result_out = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= result_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: configuration port, parser
// and result register. Depends on wsdf_pkg, wsdf_parser and wsdf_out_reg.
//
// Usage: after the opening handshake, feed the connection stream one byte
// per word on the s_ channel. Every accepted byte yields exactly one result
// word on the m_ channel: the unmasked payload byte with data_valid, the
// frame and message opcodes, frame and message end marks and an event code
// (ping, pong, close, missing mask, bad opcode or reserved bits, ignored
// after close). After a close or an error every byte reports ignored until
// reset.
// m_valid rises in the cycle after a byte is accepted; a byte is accepted
// every cycle while the result register can take its word. s_ready stays
// high while the result register is empty or being read, so a stalled
// receiver holds one word and then stalls the sender. Reset (aresetn low,
// synchronous) returns the parser to the first header byte, empties the
// result register and sets require_mask to 1.
// require_mask lies at byte address 0 of the APB port; the user must write
// it only while the block is idle, as the block itself does not enforce it.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wsdf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [wsdf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [wsdf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // Stream input
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_stream_byte,
    // Result output
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_data_valid,
    output logic      [7:0]                        m_payload_byte,
    output logic      [3:0]                        m_frame_opcode,
    output logic      [3:0]                        m_msg_opcode,
    output logic                                   m_frame_last,
    output logic                                   m_message_last,
    output logic      [2:0]                        m_event_res
);

    logic              require_mask_reg;
    logic              in_fire;
    logic              out_free;
    logic              reg_sel;
    wsdf_pkg::result_t parsed;
    wsdf_pkg::result_t held;

    // Register decode: the word address is the top address bit.
    assign reg_sel = paddr[wsdf_pkg::CFG_ADDR_W-1];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            require_mask_reg <= 1'b1;
        end else if (psel && penable && pwrite &&
                     reg_sel == wsdf_pkg::REG_REQUIRE_MASK) begin
            require_mask_reg <= pwdata[0];
        end
    end

    always_comb begin
        unique case (reg_sel)
            wsdf_pkg::REG_REQUIRE_MASK:
                prdata = {{(wsdf_pkg::CFG_DATA_W-1){1'b0}}, require_mask_reg};
            default: prdata = '0;
        endcase
    end

    // A byte enters whenever the result register can take its word.
    assign s_ready = out_free;
    assign in_fire = s_valid && out_free;

    wsdf_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (in_fire),
        .stream_byte  (s_stream_byte),
        .require_mask (require_mask_reg),
        .result       (parsed)
    );

    wsdf_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (in_fire),
        .result_in  (parsed),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .free       (out_free),
        .result_out (held)
    );

    assign m_data_valid   = held.data_valid;
    assign m_payload_byte = held.payload_byte;
    assign m_frame_opcode = held.frame_opcode;
    assign m_msg_opcode   = held.message_opcode;
    assign m_frame_last   = held.frame_last;
    assign m_message_last = held.message_last;
    assign m_event_res    = held.event_res;

endmodule

`default_nettype wire

// ===== rtl/wsdf_checker.sv =====
// Port-level checks for the WebSocket frame deframer and the bind that
// attaches them to the top level. Depends on wsdf_pkg.
`default_nettype none

module wsdf_port_props (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_data_valid,
    input wire logic [7:0] m_payload_byte,
    input wire logic       m_frame_last,
    input wire logic       m_message_last,
    input wire logic [2:0] m_event_res
);

    // A stalled result word stays valid and keeps its payload byte.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_byte))
        else $error("result word changed while stalled");

    // The sender is never stalled while the receiver takes words.
    a_ready_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    // Without data the payload byte reads zero.
    a_no_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data_valid |-> m_payload_byte == 8'h00)
        else $error("payload byte set without data");

    // A message ends only on a frame end.
    a_msg_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_message_last |-> m_frame_last)
        else $error("message end outside frame end");

    // Bytes after close carry nothing else.
    a_ignored_bare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == wsdf_pkg::EV_IGNORED |->
            !m_data_valid && !m_frame_last)
        else $error("ignored byte carries data or a frame end");

endmodule

bind websocket_frame_deframer wsdf_port_props u_wsdf_port_props (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_data_valid   (m_data_valid),
    .m_payload_byte (m_payload_byte),
    .m_frame_last   (m_frame_last),
    .m_message_last (m_message_last),
    .m_event_res    (m_event_res)
);

`default_nettype wire
